@@ hw/rtl/cbts_pkg.sv @@
package cbts_pkg;

  localparam int unsigned PRESCALER_COUNT = 64;
  localparam int unsigned OSC_W           = 26;
  localparam int unsigned RATE_W          = 20;
  localparam int unsigned BRP_W           = 6;
  localparam int unsigned CNT_W           = 5;
  localparam int unsigned OSC_RESET       = 16000000;
  localparam int unsigned TQ_MIN          = 8;
  localparam int unsigned TQ_MAX          = 25;
  localparam int unsigned SEG_MAX         = 8;
  localparam int unsigned PS2_MIN         = 2;
  localparam logic [7:0]  BYTE2_BASE      = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_Q,
    S_DIV_T,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/can_bit_timing_solver.sv @@
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_bit_rate[19:0]
// out      output     out_valid/out_stall out_found, out_cfg_byte1[5:0],
//                                         out_cfg_byte2[7:0], out_cfg_byte3[2:0]
// cfg      input      cfg_valid/cfg_ready cfg_data[25:0] (osc_freq_hz)
//
// One word fails at once when osc_freq_hz or the bit rate is zero; else it tries up to
// 64 prescalers, each trial dividing osc_freq_hz by 2 x (prescaler + 1), then by the
// bit rate, then checking the split; the divider yields 1 bit per cycle.
// Input is stalled while a word is being solved; the next word is taken while a
// finished result still waits in the output register.
// rst_n is synchronous, active low; it sets osc_freq_hz to 16000000 and idles the block.
module can_bit_timing_solver import cbts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RATE_W-1:0] in_bit_rate,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [5:0]        out_cfg_byte1,
  output logic [7:0]        out_cfg_byte2,
  output logic [2:0]        out_cfg_byte3,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [OSC_W-1:0]  cfg_data
);

  state_t state_r, state_nxt;

  logic [OSC_W-1:0]  osc_r;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [BRP_W-1:0]  brp_r, brp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OSC_W-1:0]  dvd_r, dvd_nxt;
  logic [OSC_W-1:0]  rem_r, rem_nxt;
  logic [OSC_W-1:0]  dsr_r, dsr_nxt;
  logic              ok_r, ok_nxt;
  logic [5:0]        b1_r, b1_nxt;
  logic [7:0]        b2_r, b2_nxt;
  logic [2:0]        b3_r, b3_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [5:0]        out_b1_r, out_b1_nxt;
  logic [7:0]        out_b2_r, out_b2_nxt;
  logic [2:0]        out_b3_r, out_b3_nxt;

  logic              in_acc;
  logic              out_free;
  logic              div_last;
  logic              brp_last;
  logic [OSC_W:0]    sh;
  logic [OSC_W:0]    diff;
  logic              qbit;
  logic [BRP_W:0]    brp_inc;
  logic [OSC_W-1:0]  brp_dsr;

  logic              tq_ok;
  logic [4:0]        total;
  logic [3:0]        ps2;
  logic [4:0]        rest;
  logic [3:0]        ph1;
  logic [4:0]        ph1_raw;
  logic [4:0]        prop;
  logic              split_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign div_last  = (cnt_r == CNT_W'(OSC_W - 1));
  assign brp_last  = (brp_r == BRP_W'(PRESCALER_COUNT - 1));

  assign sh      = {rem_r, dvd_r[OSC_W-1]};
  assign diff    = sh - {1'b0, dsr_r};
  assign qbit    = !diff[OSC_W];
  assign brp_inc = {1'b0, brp_r} + (BRP_W+1)'(2);
  assign brp_dsr = {{(OSC_W-BRP_W-2){1'b0}}, brp_inc, 1'b0};

  always_comb begin
    total    = dvd_r[4:0];
    tq_ok    = (rem_r == '0) && (dvd_r >= OSC_W'(TQ_MIN)) && (dvd_r <= OSC_W'(TQ_MAX));
    ps2      = 4'((6'(total) + 6'd7) >> 3);
    if (ps2 < 4'(PS2_MIN)) begin
      ps2 = 4'(PS2_MIN);
    end
    rest     = total - 5'd1 - 5'(ps2);
    ph1_raw  = 5'((6'(rest) + 6'd1) >> 1);
    ph1      = (ph1_raw > 5'(SEG_MAX)) ? 4'(SEG_MAX) : ph1_raw[3:0];
    prop     = rest - 5'(ph1);
    split_ok = tq_ok && (total >= 5'(ps2) + 5'd3) && (prop >= 5'd1)
               && (prop <= 5'(SEG_MAX)) && (ph1 >= 4'd1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (osc_r == '0 || in_bit_rate == '0) ? S_DONE : S_DIV_Q;
        end
      end
      S_DIV_Q: begin
        if (div_last) begin
          state_nxt = S_DIV_T;
        end
      end
      S_DIV_T: begin
        if (div_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = (split_ok || brp_last) ? S_DONE : S_DIV_Q;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rate_nxt      = rate_r;
    brp_nxt       = brp_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    ok_nxt        = ok_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    b3_nxt        = b3_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_b1_nxt    = out_b1_r;
    out_b2_nxt    = out_b2_r;
    out_b3_nxt    = out_b3_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (in_acc) begin
          rate_nxt = in_bit_rate;
          brp_nxt  = '0;
          cnt_nxt  = '0;
          dvd_nxt  = osc_r;
          rem_nxt  = '0;
          dsr_nxt  = OSC_W'(2);
          ok_nxt   = 1'b0;
          b1_nxt   = '0;
          b2_nxt   = '0;
          b3_nxt   = '0;
        end
      end
      S_DIV_Q, S_DIV_T: begin
        // one restoring step: shift in next dividend bit, subtract if it fits
        rem_nxt = qbit ? diff[OSC_W-1:0] : sh[OSC_W-1:0];
        dvd_nxt = {dvd_r[OSC_W-2:0], qbit};
        cnt_nxt = div_last ? '0 : cnt_r + CNT_W'(1);
        if (div_last && state_r == S_DIV_Q) begin
          dvd_nxt = {dvd_r[OSC_W-2:0], qbit};
          rem_nxt = '0;
          dsr_nxt = OSC_W'(rate_r);
        end
      end
      S_CHECK: begin
        if (split_ok) begin
          ok_nxt = 1'b1;
          b1_nxt = brp_r;
          b2_nxt = BYTE2_BASE | {2'b00, 3'(ph1 - 4'd1), 3'(prop - 5'd1)};
          b3_nxt = 3'(ps2 - 4'd1);
        end else if (!brp_last) begin
          brp_nxt = brp_r + BRP_W'(1);
          dvd_nxt = osc_r;
          rem_nxt = '0;
          dsr_nxt = brp_dsr;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = ok_r;
          out_b1_nxt    = b1_r;
          out_b2_nxt    = b2_r;
          out_b3_nxt    = b3_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      osc_r       <= OSC_W'(OSC_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        osc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rate_r    <= rate_nxt;
    brp_r     <= brp_nxt;
    cnt_r     <= cnt_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    dsr_r     <= dsr_nxt;
    ok_r      <= ok_nxt;
    b1_r      <= b1_nxt;
    b2_r      <= b2_nxt;
    b3_r      <= b3_nxt;
    out_found_r <= out_found_nxt;
    out_b1_r  <= out_b1_nxt;
    out_b2_r  <= out_b2_nxt;
    out_b3_r  <= out_b3_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_cfg_byte1 = out_b1_r;
  assign out_cfg_byte2 = out_b2_r;
  assign out_cfg_byte3 = out_b3_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_cfg_byte1 == '0 && out_cfg_byte2 == '0
                                && out_cfg_byte3 == '0)
    else $error("failed result carries nonzero bytes");

  a_found_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_cfg_byte2[7])
    else $error("found result lacks byte2 marker bit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted word");

  a_div_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_T && div_last |=> state_r == S_CHECK)
    else $error("total division did not end in check");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import cbts_pkg::*;

  localparam int unsigned PS2_NUM       = 125;
  localparam int unsigned PS2_ROUND     = 999;
  localparam int unsigned PS2_DEN       = 1000;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam logic [OSC_W-1:0]  OSC_MAX  = '1;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic       found;
    logic [5:0] brp;
    logic [7:0] seg_byte;
    logic [2:0] ps2_byte;
  } timing_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [RATE_W-1:0] in_bit_rate = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_found;
  logic [5:0]        out_cfg_byte1;
  logic [7:0]        out_cfg_byte2;
  logic [2:0]        out_cfg_byte3;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [OSC_W-1:0]  cfg_data = '0;

  timing_t          timing_q[$];
  logic [OSC_W-1:0] osc_hz = OSC_W'(OSC_RESET);
  int               src_idle_pct = 0;
  int               dst_stall_pct = 0;
  int               fail_count = 0;
  int unsigned      quiet_cycles = 0;

  can_bit_timing_solver dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_bit_rate   (in_bit_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_cfg_byte1 (out_cfg_byte1),
    .out_cfg_byte2 (out_cfg_byte2),
    .out_cfg_byte3 (out_cfg_byte3),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic timing_t solve_timing(input logic [OSC_W-1:0] osc,
                                           input logic [RATE_W-1:0] rate);
    timing_t     res;
    int unsigned brp, qclk, total, ps2, rest, ph1, prop;
    res = '0;
    if (osc != 0 && rate != 0) begin
      for (brp = 0; brp < PRESCALER_COUNT && brp < (1 << BRP_W) && !res.found; brp++) begin
        qclk = 32'(osc) / (2 * (brp + 1));
        total = qclk / 32'(rate);
        ps2 = (total * PS2_NUM + PS2_ROUND) / PS2_DEN;
        if (ps2 < PS2_MIN) ps2 = PS2_MIN;
        if (ps2 > SEG_MAX) ps2 = SEG_MAX;
        rest = total - 1 - ps2;
        ph1 = (rest + 1) / 2;
        if (ph1 > SEG_MAX) ph1 = SEG_MAX;
        prop = rest - ph1;
        if (qclk % 32'(rate) == 0 && total >= TQ_MIN && total <= TQ_MAX &&
            total >= ps2 + 3 && prop >= 1 && prop <= SEG_MAX && ph1 >= 1) begin
          res.found = 1'b1;
          res.brp = brp[5:0];
          res.seg_byte = BYTE2_BASE | 8'((ph1 - 1) << 3) | 8'(prop - 1);
          res.ps2_byte = 3'(ps2 - 1);
        end
      end
    end
    return res;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    int unsigned sel, qclk;
    sel = $urandom_range(99);
    if (sel < 60) begin
      qclk = 32'(osc_hz) / (2 * $urandom_range(1, PRESCALER_COUNT));
      return RATE_W'(qclk / $urandom_range(TQ_MIN, TQ_MAX));
    end
    if (sel < 75) begin
      case ($urandom_range(5))
        0: return RATE_W'(1000000);
        1: return RATE_W'(500000);
        2: return RATE_W'(250000);
        3: return RATE_W'(125000);
        4: return RATE_W'(50000);
        default: return RATE_W'(10000);
      endcase
    end
    return RATE_W'($urandom);
  endfunction

  function automatic logic [OSC_W-1:0] pick_osc();
    case ($urandom_range(5))
      0: return OSC_W'(OSC_RESET);
      1: return OSC_W'(8000000);
      2: return OSC_W'(20000000);
      3: return OSC_W'(24000000);
      4: return OSC_W'(40000000);
      default: return OSC_W'($urandom);
    endcase
  endfunction

  task automatic send_rate(input logic [RATE_W-1:0] rate);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_bit_rate <= rate;
    do @(posedge clk); while (in_stall);
    timing_q.push_back(solve_timing(osc_hz, rate));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (timing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_osc(input logic [OSC_W-1:0] freq);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= freq;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    osc_hz = freq;
  endtask

  task automatic test_reset_frequency();
    send_rate('0);
    send_rate(RATE_MAX);
    send_rate(1000000);
    send_rate(500000);
    send_rate(250000);
    send_rate(125000);
    send_rate(83333);
    send_rate(10000);
    send_rate(1);
    wait_drained();
    send_rate(20000);
    send_rate(50000);
  endtask

  task automatic test_zero_frequency();
    write_osc('0);
    send_rate(500000);
    send_rate(RATE_MAX);
  endtask

  task automatic test_frequency_extremes();
    write_osc(OSC_MAX);
    send_rate(1000000);
    send_rate(125000);
    write_osc(40000000);
    send_rate(1000000);
    send_rate(250000);
    write_osc(1);
    send_rate(1);
  endtask

  task automatic test_random_rates();
    int mode, k;
    for (mode = 0; mode < 4; mode++) begin
      for (k = 0; k < 2; k++) begin
        write_osc(pick_osc());
        case (mode)
          0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
          1: begin src_idle_pct = 61; dst_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  dst_stall_pct = 61; end
          default: begin src_idle_pct = 13; dst_stall_pct = 13; end
        endcase
        repeat (15) send_rate(pick_rate());
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  always @(posedge clk) begin : check_result
    timing_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_found, out_cfg_byte1, out_cfg_byte2, out_cfg_byte3};
      if (timing_q.size() == 0) begin
        $display("%0t: unexpected word found=%0d b1=%h b2=%h b3=%h", $time,
                 got.found, got.brp, got.seg_byte, got.ps2_byte);
        fail_count++;
      end else begin
        want = timing_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected found=%0d b1=%h b2=%h b3=%h, got found=%0d b1=%h b2=%h b3=%h",
                   $time, want.found, want.brp, want.seg_byte, want.ps2_byte,
                   got.found, got.brp, got.seg_byte, got.ps2_byte);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    osc_hz = OSC_W'(OSC_RESET);
    test_reset_frequency();
    test_zero_frequency();
    test_frequency_extremes();
    test_random_rates();
    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
